/* design/voc_sbe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voc_sbe_pkg
// Shared types and constants for the VOC sound block extractor.
// ----------------------------------------------------------------------------
package voc_sbe_pkg;

    localparam int VOC_POS_BITS_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 24;

    // header: data offset lives in bytes 20 and 21, first legal block at 22
    localparam int HDR_OFF_LO_POS = 20;
    localparam int HDR_OFF_HI_POS = 21;
    localparam logic [15:0] MIN_DATA_OFFSET = 16'd22;

    // block tags
    localparam logic [BYTE_W-1:0] TAG_TERMINATOR = 8'd0;
    localparam logic [BYTE_W-1:0] TAG_SOUND      = 8'd1;
    localparam logic [BYTE_W-1:0] TAG_MAX_KNOWN  = 8'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SAMPLE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TERMINATOR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_TAG = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT_BLOCK = 3'd5;

    // m_tdata layout, lowest bit first: sample, rate_code, codec
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic                emit;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] sample;
        logic [BYTE_W-1:0]   rate_code;
        logic [BYTE_W-1:0]   codec;
    } result_t;

endpackage
`default_nettype wire

/* design/voc_sbe_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voc_sbe_parser
// Block-chain walker: parse state and the per-byte next-state/result logic.
// ----------------------------------------------------------------------------
module voc_sbe_parser #(
    parameter int POSITION_BITS = voc_sbe_pkg::VOC_POS_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,      // consume the held byte
    input  wire logic [voc_sbe_pkg::BYTE_W-1:0] file_byte,
    input  wire logic                         file_end,
    output voc_sbe_pkg::result_t              result     // for the held byte
);
    import voc_sbe_pkg::*;

    localparam int P     = POSITION_BITS;
    localparam int SUM_W = ((P > LEN_W) ? P : LEN_W) + 1;

    typedef enum logic [7:0] {
        PH_HEADER   = 8'b0000_0001,
        PH_SEEK     = 8'b0000_0010,
        PH_SKIPLEN  = 8'b0000_0100,
        PH_SOUNDLEN = 8'b0000_1000,
        PH_RATE     = 8'b0001_0000,
        PH_CODEC    = 8'b0010_0000,
        PH_SAMPLES  = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [P-1:0]       pos_reg, pos_next;
    logic [P-1:0]       nbs_reg, nbs_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [1:0]         lcnt_reg, lcnt_next;
    logic [BYTE_W-1:0]  rate_reg, rate_next;
    logic [BYTE_W-1:0]  codec_reg, codec_next;

    logic [15:0]        offset;
    logic [LEN_W-1:0]   full_len;
    logic [SUM_W-1:0]   skip_sum;
    logic               emit;
    logic               lastf;
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] smp;

    assign offset   = {file_byte, acc_reg[7:0]};
    assign full_len = {file_byte, acc_reg[15:0]};
    assign skip_sum = SUM_W'(pos_reg) + SUM_W'(full_len) + SUM_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg + P'(1);
        nbs_next   = nbs_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        lcnt_next  = lcnt_reg;
        rate_next  = rate_reg;
        codec_next = codec_reg;
        emit       = 1'b0;
        lastf      = 1'b0;
        status     = ST_SAMPLE;
        smp        = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == P'(HDR_OFF_LO_POS))
                begin
                    acc_next = LEN_W'(file_byte);
                end
                else if (pos_reg == P'(HDR_OFF_HI_POS))
                begin
                    if (offset < MIN_DATA_OFFSET)
                    begin
                        emit       = 1'b1;
                        lastf      = 1'b1;
                        status     = ST_BAD_OFFSET;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        nbs_next   = P'(offset);
                        phase_next = PH_SEEK;
                    end
                end
            end
            PH_SEEK:
            begin
                if (pos_reg == nbs_reg)
                begin
                    acc_next  = '0;
                    lcnt_next = 2'd0;
                    if (file_byte == TAG_TERMINATOR)
                    begin
                        emit       = 1'b1;
                        lastf      = 1'b1;
                        status     = ST_TERMINATOR;
                        phase_next = PH_DONE;
                    end
                    else if (file_byte == TAG_SOUND)
                    begin
                        phase_next = PH_SOUNDLEN;
                    end
                    else if (file_byte <= TAG_MAX_KNOWN)
                    begin
                        phase_next = PH_SKIPLEN;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        lastf      = 1'b1;
                        status     = ST_UNKNOWN_TAG;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_SKIPLEN, PH_SOUNDLEN:
            begin
                // three length bytes follow the tag, little endian
                case (lcnt_reg)
                    2'd0:
                    begin
                        acc_next  = LEN_W'(file_byte);
                        lcnt_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next  = {8'h00, file_byte, acc_reg[7:0]};
                        lcnt_next = 2'd2;
                    end
                    default:
                    begin
                        acc_next = full_len;
                        if (phase_reg == PH_SKIPLEN)
                        begin
                            nbs_next   = skip_sum[P-1:0];
                            phase_next = PH_SEEK;
                        end
                        else if (full_len < LEN_W'(2))
                        begin
                            emit       = 1'b1;
                            lastf      = 1'b1;
                            status     = ST_SHORT_BLOCK;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            left_next  = full_len - LEN_W'(2);
                            phase_next = PH_RATE;
                        end
                    end
                endcase
            end
            PH_RATE:
            begin
                rate_next  = file_byte;
                phase_next = PH_CODEC;
            end
            PH_CODEC:
            begin
                codec_next = file_byte;
                phase_next = (left_reg != '0) ? PH_SAMPLES : PH_DONE;
            end
            PH_SAMPLES:
            begin
                emit      = 1'b1;
                smp       = {file_byte ^ 8'h80, 8'h00};
                left_next = left_reg - LEN_W'(1);
                if (left_next == '0)
                begin
                    lastf      = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                // done: bytes are dropped until file end
            end
        endcase

        // file ends before the walk finished
        if (file_end && (phase_next != PH_DONE))
        begin
            if (!(emit && (status == ST_SAMPLE)))
            begin
                smp = '0;
            end
            emit   = 1'b1;
            lastf  = 1'b1;
            status = ST_TRUNCATED;
        end
    end

    always_comb
    begin
        result.emit      = emit;
        result.last      = lastf;
        result.status    = status;
        result.sample    = smp;
        result.rate_code = rate_next;
        result.codec     = codec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            nbs_reg   <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            lcnt_reg  <= 2'd0;
            rate_reg  <= '0;
            codec_reg <= '0;
        end
        else if (step)
        begin
            if (file_end)
            begin
                phase_reg <= PH_HEADER;
                pos_reg   <= '0;
                nbs_reg   <= '0;
                acc_reg   <= '0;
                left_reg  <= '0;
                lcnt_reg  <= 2'd0;
                rate_reg  <= '0;
                codec_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                nbs_reg   <= nbs_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                lcnt_reg  <= lcnt_next;
                rate_reg  <= rate_next;
                codec_reg <= codec_next;
            end
        end
    end

endmodule
`default_nettype wire

/* design/voc_sbe_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voc_sbe_out_stage
// Result register on the master side; holds a transaction until taken.
// ----------------------------------------------------------------------------
module voc_sbe_out_stage (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire voc_sbe_pkg::result_t                 result,
    output logic                                      tvalid,
    input  wire logic                                 tready,
    output logic [voc_sbe_pkg::OUT_DATA_W-1:0]        tdata,
    output logic [voc_sbe_pkg::STATUS_W-1:0]          tuser,
    output logic                                      tlast
);
    import voc_sbe_pkg::*;

    logic                valid_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [BYTE_W-1:0]   rate_reg;
    logic [BYTE_W-1:0]   codec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg   <= result.last;
            status_reg <= result.status;
            sample_reg <= result.sample;
            rate_reg   <= result.rate_code;
            codec_reg  <= result.codec;
        end
    end

    assign tvalid = valid_reg;
    assign tlast  = last_reg;
    assign tuser  = status_reg;
    assign tdata  = {codec_reg, rate_reg, sample_reg};

endmodule
`default_nettype wire

/* design/voc_sound_block_extractor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voc_sound_block_extractor
// Walks the block chain of a VOC byte stream and emits the samples of the
// first sound block, or one status transaction when the walk reaches a terminator or fails.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                          tuser         tlast
//  -------  ---  -----------------------------  ------------  -------------------
//  s_*      in   [7:0] file_byte                -             file_end
//  m_*      out  [15:0] sample,                 [2:0] status  last result of file
//                [23:16] rate_code, [31:24] codec
//
//  One byte per cycle sustained while no result waits on m_tready. A byte
//  sits in the input register, then the parser settles it and a result,
//  if any, lands in the output register, which drives the m_* channel.
//  Bytes that make no result never wait on m_tready; a byte that makes
//  a result waits only while the output register is full and not taken.
//  rst_n clears all parse state; the byte marked with tlast does the same
//  once it is consumed, so files may follow back to back.
//
module voc_sound_block_extractor #(
    parameter int POSITION_BITS = voc_sbe_pkg::VOC_POS_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [voc_sbe_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] file_byte
    input  wire logic                                 s_tlast,   // file_end
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [15:0] sample, [23:16] rate_code, [31:24] codec
    output logic [voc_sbe_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [voc_sbe_pkg::STATUS_W-1:0]          m_tuser,   // [2:0] status
    output logic                                      m_tlast    // last
);
    import voc_sbe_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;

    result_t           result;
    logic              advance;    // parser consumes the held byte this cycle
    logic              in_take;

    // the held byte may move on unless it makes a result and the output
    // register is still occupied
    assign advance  = in_valid_reg && (!result.emit || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    voc_sbe_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .file_byte (in_byte_reg),
        .file_end  (in_end_reg),
        .result    (result)
    );

    voc_sbe_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && result.emit),
        .result (result),
        .tvalid (m_tvalid),
        .tready (m_tready),
        .tdata  (m_tdata),
        .tuser  (m_tuser),
        .tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a pending result is never overwritten by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && in_valid_reg && result.emit) |-> !advance)
        else $error("output register overwritten while stalled");

    // every status other than a sample ends the file
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_SAMPLE)) |-> m_tlast)
        else $error("status transaction without last");

    // an empty input register always takes a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // a byte that makes no result never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !result.emit) |-> advance)
        else $error("byte without result stalled");

endmodule
`default_nettype wire
